// File: hw/rtl/pfa_pkg.sv
// Shared definitions for the periodic fold accumulator: field widths, register
// indexes, request kinds and the command/status bundles between controller and datapath.
// No dependencies.
package pfa_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_BINS    = 1024;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_ACC_BITS    = 32;

    // Fixed field widths.
    localparam int LEN_BITS       = 11;
    localparam int START_BITS     = 10;
    localparam int INDEX_BITS     = 10;
    localparam int KIND_BITS      = 2;
    localparam int OUT_BITS       = 32;
    localparam int CFG_INDEX_BITS = 1;
    localparam int RESET_FOLD_LEN = 1024;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_FOLD_LENGTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_OFFSET = 1'd1;

    // Request kinds carried on s_tuser.
    typedef enum logic [KIND_BITS-1:0] {
        KIND_ACCUM   = 2'd0,
        KIND_READ    = 2'd1,
        KIND_RESTART = 2'd2
    } pfa_kind_t;

    typedef struct packed {
        logic accept;      // input request taken this cycle
        logic clear_wr;    // write zeros at the sweep address
        logic upd;         // finish the accepted request (write back, output)
        logic restart;     // position back to start offset
        logic cfg_pop;     // take the next queued register write
        logic rem_start;   // launch the remainder unit
        logic rem_of_pos;  // remainder operand is the position
        logic wr_start;    // store remainder into start offset
        logic wr_pos;      // store remainder into position
    } pfa_cmd_t;

    typedef struct packed {
        logic cfg_pending;
        logic cur_is_len;
        logic clear_last;
        logic rem_done;
        logic item_is_read;
        logic out_busy;
    } pfa_stat_t;

endpackage

// File: hw/rtl/periodic_fold_accumulator_unit.sv
// Periodic fold accumulator: sample n after a restart adds into bin
// (start_offset + n) mod fold_length, with 32-bit saturating sums and a sticky
// clip flag per bin; a read request returns one bin and clears it. After reset
// the bin memory is swept to zero one entry per cycle, all MAX_BINS entries,
// before the first request is taken. An accumulate or read request occupies
// the block for a bin memory read, then a write back through its single write
// port; a restart or an unused kind is finished when it is taken. A start_offset
// write is reduced modulo the fold length by a remainder unit; a fold_length write
// is clamped to 1..MAX_BINS, then start offset and position are both reduced.
// Requests are held off during the reduction. Up to four writes are queued.
// A result waits in an output register while further requests are taken.
// Depends on pfa_pkg, pfa_ctrl, pfa_datapath and pfa_rem_unit.
module periodic_fold_accumulator_unit #(
    parameter int MAX_BINS    = pfa_pkg::DEF_MAX_BINS,
    parameter int SAMPLE_BITS = pfa_pkg::DEF_SAMPLE_BITS,
    parameter int ACC_BITS    = pfa_pkg::DEF_ACC_BITS,
    parameter int S_TDATA_W   = ((2 * SAMPLE_BITS + pfa_pkg::INDEX_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample_re, sample_im, bin_index, zero padding
    input  logic [S_TDATA_W-1:0]               s_tdata,
    // kind
    input  logic [pfa_pkg::KIND_BITS-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // sum_re, sum_im
    output logic [2*pfa_pkg::OUT_BITS-1:0]     m_tdata,
    // saturated
    output logic                               m_tuser,
    input  logic                               cfg_we,
    input  logic [pfa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pfa_pkg::LEN_BITS-1:0]       cfg_wdata
);

    pfa_pkg::pfa_cmd_t  cmd_w;
    pfa_pkg::pfa_stat_t stat_w;

    pfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_kind  (s_tuser),
        .stat     (stat_w),
        .cmd      (cmd_w),
        .s_tready (s_tready)
    );

    pfa_datapath #(
        .MAX_BINS    (MAX_BINS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS),
        .S_TDATA_W   (S_TDATA_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd_w),
        .stat      (stat_w),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // An accumulate or read request keeps the input closed for its write-back cycle.
    a_busy_after_rmw : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready &&
         (s_tuser == pfa_pkg::KIND_ACCUM || s_tuser == pfa_pkg::KIND_READ))
        |=> !s_tready)
        else $error("input taken during a bin update");

    // A register write must be reduced before the next request is taken.
    a_cfg_blocks_input : assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("input taken with a register write still queued");

    // A result appears only from the completion of a read request.
    a_result_from_read : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd_w.upd && stat_w.item_is_read))
        else $error("result without a read request");

endmodule

// File: hw/rtl/pfa_rem_unit.sv
// Restoring remainder unit: one dividend bit per cycle, all LEN_BITS bits per result.
// Depends on pfa_pkg.
module pfa_rem_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pfa_pkg::LEN_BITS-1:0] dividend,
    input  logic [pfa_pkg::LEN_BITS-1:0] divisor,
    output logic                         done,
    output logic [pfa_pkg::LEN_BITS-1:0] remainder
);

    localparam int LW    = pfa_pkg::LEN_BITS;
    localparam int CNT_W = $clog2(LW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [LW-1:0]    rem_reg;
    logic [LW-1:0]    shift_reg;
    logic [LW:0]      rem_try;
    logic [LW:0]      rem_sub;
    logic [LW-1:0]    rem_next;

    always_comb begin
        rem_try = {rem_reg, shift_reg[LW-1]};
        rem_sub = rem_try - {1'b0, divisor};
        if (rem_try >= {1'b0, divisor}) begin
            rem_next = rem_sub[LW-1:0];
        end else begin
            rem_next = rem_try[LW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(LW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= '0;
            shift_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[LW-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: hw/rtl/pfa_ctrl.sv
// Controller for the periodic fold accumulator: bin clearing sweep, request
// sequencing and register-write reduction. Depends on pfa_pkg.
module pfa_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic [pfa_pkg::KIND_BITS-1:0] in_kind,
    input  pfa_pkg::pfa_stat_t            stat,
    output pfa_pkg::pfa_cmd_t             cmd,
    output logic                          s_tready
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_CFG   = 6'b000100,
        ST_UPD   = 6'b001000,
        ST_DIV_S = 6'b010000,
        ST_DIV_P = 6'b100000
    } pfa_state_t;

    pfa_state_t state_reg;
    pfa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // Queued register writes go first so every request sees them.
                if (stat.cfg_pending) begin
                    cmd.cfg_pop = 1'b1;
                    state_next  = ST_CFG;
                end else begin
                    s_tready = 1'b1;
                    if (s_tvalid) begin
                        cmd.accept = 1'b1;
                        case (in_kind) inside
                            pfa_pkg::KIND_ACCUM, pfa_pkg::KIND_READ: begin
                                state_next = ST_UPD;
                            end
                            pfa_pkg::KIND_RESTART: begin
                                cmd.restart = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            ST_CFG: begin
                cmd.rem_start = 1'b1;
                state_next    = ST_DIV_S;
            end
            ST_UPD: begin
                // A read waits here until the output register can take its result.
                if (!(stat.item_is_read && stat.out_busy)) begin
                    cmd.upd    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_S: begin
                if (stat.rem_done) begin
                    cmd.wr_start = 1'b1;
                    if (stat.cur_is_len) begin
                        cmd.rem_start  = 1'b1;
                        cmd.rem_of_pos = 1'b1;
                        state_next     = ST_DIV_P;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV_P: begin
                if (stat.rem_done) begin
                    cmd.wr_pos = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// File: hw/rtl/pfa_datapath.sv
// Datapath of the periodic fold accumulator: bin memory, saturating adders,
// configuration registers and write queue, position, output register.
// Depends on pfa_pkg and pfa_rem_unit.
module pfa_datapath #(
    parameter int MAX_BINS    = pfa_pkg::DEF_MAX_BINS,
    parameter int SAMPLE_BITS = pfa_pkg::DEF_SAMPLE_BITS,
    parameter int ACC_BITS    = pfa_pkg::DEF_ACC_BITS,
    parameter int S_TDATA_W   = ((2 * SAMPLE_BITS + pfa_pkg::INDEX_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pfa_pkg::pfa_cmd_t                  cmd,
    output pfa_pkg::pfa_stat_t                 stat,
    input  logic [pfa_pkg::KIND_BITS-1:0]      s_tuser,
    input  logic [S_TDATA_W-1:0]               s_tdata,
    input  logic                               cfg_we,
    input  logic [pfa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pfa_pkg::LEN_BITS-1:0]       cfg_wdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [2*pfa_pkg::OUT_BITS-1:0]     m_tdata,
    output logic                               m_tuser
);

    localparam int LW        = pfa_pkg::LEN_BITS;
    localparam int IW        = pfa_pkg::INDEX_BITS;
    localparam int OB        = pfa_pkg::OUT_BITS;
    localparam int AW        = $clog2(MAX_BINS);
    localparam int WORD_W    = 2 * ACC_BITS + 1;
    localparam int SUM_W     = ((ACC_BITS > SAMPLE_BITS) ? ACC_BITS : SAMPLE_BITS) + 1;
    localparam int EXT_W     = 64;
    localparam int LEN_LIMIT = (1 << LW) - 1;
    localparam int MAX_LEN   = (MAX_BINS < LEN_LIMIT) ? MAX_BINS : LEN_LIMIT;
    localparam int RESET_LEN = (pfa_pkg::RESET_FOLD_LEN > MAX_BINS) ? MAX_BINS
                                                                     : pfa_pkg::RESET_FOLD_LEN;
    localparam int FIFO_DEPTH = 4;
    localparam int FP_W       = $clog2(FIFO_DEPTH);
    localparam int FC_W       = FP_W + 1;
    localparam int FE_W       = pfa_pkg::CFG_INDEX_BITS + LW;

    // Saturating add of a sample into an accumulator; the top bit reports a clip.
    function automatic logic [ACC_BITS:0] sat_add(input logic [ACC_BITS-1:0]    acc,
                                                  input logic [SAMPLE_BITS-1:0] smp);
        logic signed [SUM_W-1:0] a_x;
        logic signed [SUM_W-1:0] s_x;
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic [ACC_BITS:0]       res;
        a_x = {{(SUM_W - ACC_BITS){acc[ACC_BITS-1]}}, acc};
        s_x = {{(SUM_W - SAMPLE_BITS){smp[SAMPLE_BITS-1]}}, smp};
        hi  = {{(SUM_W - ACC_BITS + 1){1'b0}}, {(ACC_BITS - 1){1'b1}}};
        lo  = ~hi;
        sum = a_x + s_x;
        if (sum > hi) begin
            res = {1'b1, hi[ACC_BITS-1:0]};
        end else if (sum < lo) begin
            res = {1'b1, lo[ACC_BITS-1:0]};
        end else begin
            res = {1'b0, sum[ACC_BITS-1:0]};
        end
        return res;
    endfunction

    // Input fields.
    logic [SAMPLE_BITS-1:0] in_re;
    logic [SAMPLE_BITS-1:0] in_im;
    logic [IW-1:0]          in_bin;

    assign in_re  = s_tdata[SAMPLE_BITS-1:0];
    assign in_im  = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign in_bin = s_tdata[2*SAMPLE_BITS+IW-1:2*SAMPLE_BITS];

    // Accepted request.
    logic                   item_read_reg;
    logic                   item_in_range_reg;
    logic [AW-1:0]          item_addr_reg;
    logic [SAMPLE_BITS-1:0] item_re_reg;
    logic [SAMPLE_BITS-1:0] item_im_reg;
    logic                   in_is_read;

    assign in_is_read = (s_tuser == pfa_pkg::KIND_READ);

    // Configuration and position registers.
    logic [LW-1:0] fold_len_reg;
    logic [AW-1:0] start_reg;
    logic [AW-1:0] pos_reg;

    // Register-write queue.
    logic [FE_W-1:0] cfg_fifo_mem [FIFO_DEPTH];
    logic [FP_W-1:0] fifo_wr_reg;
    logic [FP_W-1:0] fifo_rd_reg;
    logic [FC_W-1:0] fifo_cnt_reg;
    logic            fifo_push;
    logic [FE_W-1:0] fifo_head;
    logic            head_is_len;
    logic [LW-1:0]   head_val;
    logic [LW-1:0]   len_clamped;
    logic            cur_is_len_reg;
    logic [LW-1:0]   cur_val_reg;

    assign fifo_push   = cfg_we && (fifo_cnt_reg != FC_W'(FIFO_DEPTH));
    assign fifo_head   = cfg_fifo_mem[fifo_rd_reg];
    assign head_is_len = (fifo_head[FE_W-1:LW] == pfa_pkg::REG_FOLD_LENGTH);
    assign head_val    = fifo_head[LW-1:0];

    always_comb begin
        if (head_val == '0) begin
            len_clamped = LW'(1);
        end else if (head_val > LW'(MAX_LEN)) begin
            len_clamped = LW'(MAX_LEN);
        end else begin
            len_clamped = head_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (fifo_push) begin
            cfg_fifo_mem[fifo_wr_reg] <= {cfg_index, cfg_wdata};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_wr_reg  <= '0;
            fifo_rd_reg  <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (fifo_push) begin
                fifo_wr_reg <= fifo_wr_reg + 1'b1;
            end
            if (cmd.cfg_pop) begin
                fifo_rd_reg <= fifo_rd_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_reg + FC_W'(fifo_push) - FC_W'(cmd.cfg_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cfg_pop) begin
            cur_is_len_reg <= head_is_len;
            cur_val_reg    <= head_val;
        end
    end

    // Width conversions between bin addresses and the remainder unit.
    logic [AW+LW-1:0] pos_wide;
    logic [AW+LW-1:0] start_wide;
    logic [AW+LW-1:0] rem_wide;
    logic [AW+IW-1:0] bin_wide;
    logic [LW-1:0]    pos_len;
    logic [LW-1:0]    start_len;
    logic [AW-1:0]    rem_addr;
    logic [AW-1:0]    bin_addr;
    logic [LW-1:0]    rem_dividend;
    logic             rem_done;
    logic [LW-1:0]    rem_value;

    assign pos_wide   = {{LW{1'b0}}, pos_reg};
    assign start_wide = {{LW{1'b0}}, start_reg};
    assign rem_wide   = {{AW{1'b0}}, rem_value};
    assign bin_wide   = {{AW{1'b0}}, in_bin};
    assign pos_len    = pos_wide[LW-1:0];
    assign start_len  = start_wide[LW-1:0];
    assign rem_addr   = rem_wide[AW-1:0];
    assign bin_addr   = bin_wide[AW-1:0];

    always_comb begin
        if (cmd.rem_of_pos) begin
            rem_dividend = pos_len;
        end else if (cur_is_len_reg) begin
            rem_dividend = start_len;
        end else begin
            rem_dividend = {1'b0, cur_val_reg[pfa_pkg::START_BITS-1:0]};
        end
    end

    pfa_rem_unit u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.rem_start),
        .dividend  (rem_dividend),
        .divisor   (fold_len_reg),
        .done      (rem_done),
        .remainder (rem_value)
    );

    // Next position after an accumulate, wrapping at the fold length.
    logic [LW:0]      pos_inc;
    logic [AW+LW:0]   pos_inc_wide;
    logic [AW-1:0]    pos_adv;

    assign pos_inc      = {1'b0, pos_len} + 1'b1;
    assign pos_inc_wide = {{AW{1'b0}}, pos_inc};
    assign pos_adv      = (pos_inc >= {1'b0, fold_len_reg}) ? '0 : pos_inc_wide[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_len_reg <= LW'(RESET_LEN);
            start_reg    <= '0;
            pos_reg      <= '0;
        end else begin
            if (cmd.cfg_pop && head_is_len) begin
                fold_len_reg <= len_clamped;
            end
            if (cmd.wr_start) begin
                start_reg <= rem_addr;
            end
            if (cmd.wr_pos) begin
                pos_reg <= rem_addr;
            end else if (cmd.restart) begin
                pos_reg <= start_reg;
            end else if (cmd.upd && !item_read_reg) begin
                pos_reg <= pos_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_read_reg     <= in_is_read;
            item_in_range_reg <= ({1'b0, in_bin} < fold_len_reg);
            item_addr_reg     <= in_is_read ? bin_addr : pos_reg;
            item_re_reg       <= in_re;
            item_im_reg       <= in_im;
        end
    end

    // Bin memory: {clip flag, imaginary sum, real sum} per entry.
    logic [WORD_W-1:0] bin_mem [MAX_BINS];
    logic [WORD_W-1:0] rd_word_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [ACC_BITS:0] add_re;
    logic [ACC_BITS:0] add_im;
    logic [WORD_W-1:0] acc_word;

    assign add_re   = sat_add(rd_word_reg[ACC_BITS-1:0], item_re_reg);
    assign add_im   = sat_add(rd_word_reg[2*ACC_BITS-1:ACC_BITS], item_im_reg);
    assign acc_word = {rd_word_reg[2*ACC_BITS] | add_re[ACC_BITS] | add_im[ACC_BITS],
                       add_im[ACC_BITS-1:0], add_re[ACC_BITS-1:0]};

    assign mem_we    = cmd.clear_wr || (cmd.upd && (!item_read_reg || item_in_range_reg));
    assign mem_waddr = cmd.clear_wr ? clr_cnt_reg : item_addr_reg;
    assign mem_wdata = (cmd.clear_wr || item_read_reg) ? '0 : acc_word;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bin_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_word_reg <= bin_mem[in_is_read ? bin_addr : pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_wr) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Output register.
    logic              m_tvalid_reg;
    logic [2*OB-1:0]   m_tdata_reg;
    logic              m_tuser_reg;
    logic              out_load;
    logic [EXT_W-1:0]  re_ext;
    logic [EXT_W-1:0]  im_ext;

    assign out_load = cmd.upd && item_read_reg;
    assign re_ext   = {{(EXT_W - ACC_BITS){rd_word_reg[ACC_BITS-1]}},
                       rd_word_reg[ACC_BITS-1:0]};
    assign im_ext   = {{(EXT_W - ACC_BITS){rd_word_reg[2*ACC_BITS-1]}},
                       rd_word_reg[2*ACC_BITS-1:ACC_BITS]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            // A bin beyond the fold length reads as zero with no flag.
            if (item_in_range_reg) begin
                m_tdata_reg <= {im_ext[OB-1:0], re_ext[OB-1:0]};
                m_tuser_reg <= rd_word_reg[2*ACC_BITS];
            end else begin
                m_tdata_reg <= '0;
                m_tuser_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign stat.cfg_pending  = (fifo_cnt_reg != '0);
    assign stat.cur_is_len   = cur_is_len_reg;
    assign stat.clear_last   = (clr_cnt_reg == AW'(MAX_BINS - 1));
    assign stat.rem_done     = rem_done;
    assign stat.item_is_read = item_read_reg;
    assign stat.out_busy     = m_tvalid_reg && !m_tready;

endmodule

// File: sim/pfa_checker.sv
// Result checker for the periodic fold accumulator: watches the request, result and
// register-write ports, keeps its own copy of the bin store, and compares each result
// with the oldest outstanding read. Depends on pfa_pkg.
module pfa_checker
    import pfa_pkg::*;
#(
    parameter int NUM_BINS  = DEF_MAX_BINS,
    parameter int S_TDATA_W = 48
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    // sample_re, sample_im, bin_index, zero padding
    input  logic [S_TDATA_W-1:0]      s_tdata,
    // kind
    input  logic [KIND_BITS-1:0]      s_tuser,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    // sum_re, sum_im
    input  logic [2*OUT_BITS-1:0]     m_tdata,
    // saturated
    input  logic                      m_tuser,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [LEN_BITS-1:0]       cfg_wdata,
    output int                        mismatches,
    output int                        pending,
    output int                        requests_seen,
    output int                        reads_checked,
    output int                        clipped_reads
);

    localparam int     SMP_W        = DEF_SAMPLE_BITS;
    localparam longint SUM_MAX      = (longint'(1) <<< (OUT_BITS - 1)) - 1;
    localparam longint SUM_MIN      = -SUM_MAX - 1;
    localparam int     REPORT_LIMIT = 10;

    typedef logic signed [OUT_BITS-1:0] sum_t;
    typedef logic signed [SMP_W-1:0]    sample_t;

    typedef struct packed {
        sum_t re;
        sum_t im;
        logic sat;
    } bin_read_t;

    sum_t        bin_sum_re [NUM_BINS];
    sum_t        bin_sum_im [NUM_BINS];
    logic        bin_sat    [NUM_BINS];
    int unsigned fold_len;
    int unsigned first_bin;
    int unsigned next_bin;
    bin_read_t   read_q[$];
    int          errs   = 0;
    int          n_req  = 0;
    int          n_read = 0;
    int          n_clip = 0;

    function automatic sum_t add_clipped(input sum_t acc, input sample_t smp, inout logic clip);
        longint total;
        total = longint'(acc) + longint'(smp);
        if (total > SUM_MAX) begin
            clip = 1'b1;
            return sum_t'(SUM_MAX);
        end
        if (total < SUM_MIN) begin
            clip = 1'b1;
            return sum_t'(SUM_MIN);
        end
        return sum_t'(total);
    endfunction

    task automatic apply_reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                   input logic [LEN_BITS-1:0] val);
        int unsigned len;
        if (idx == REG_FOLD_LENGTH) begin
            len = val;
            if (len == 0) len = 1;
            if (len > NUM_BINS) len = NUM_BINS;
            fold_len  = len;
            // Bins keep their contents; only the two pointers are folded into range.
            first_bin = first_bin % fold_len;
            next_bin  = next_bin % fold_len;
        end else begin
            first_bin = val[START_BITS-1:0] % fold_len;
        end
    endtask

    task automatic take_request(input logic [KIND_BITS-1:0] kind,
                                input logic [S_TDATA_W-1:0] data);
        sample_t     re;
        sample_t     im;
        int unsigned idx;
        logic        clip;
        bin_read_t   outcome;
        re   = data[SMP_W-1:0];
        im   = data[2*SMP_W-1:SMP_W];
        idx  = data[2*SMP_W+INDEX_BITS-1:2*SMP_W];
        clip = 1'b0;
        case (kind)
            KIND_ACCUM: begin
                bin_sum_re[next_bin] = add_clipped(bin_sum_re[next_bin], re, clip);
                bin_sum_im[next_bin] = add_clipped(bin_sum_im[next_bin], im, clip);
                if (clip) bin_sat[next_bin] = 1'b1;
                next_bin = (next_bin + 1 >= fold_len) ? 0 : next_bin + 1;
            end
            KIND_READ: begin
                outcome.re  = '0;
                outcome.im  = '0;
                outcome.sat = 1'b0;
                // A read past the folded period answers with zeros and leaves the store alone.
                if (idx < fold_len) begin
                    outcome.re      = bin_sum_re[idx];
                    outcome.im      = bin_sum_im[idx];
                    outcome.sat     = bin_sat[idx];
                    bin_sum_re[idx] = '0;
                    bin_sum_im[idx] = '0;
                    bin_sat[idx]    = 1'b0;
                end
                read_q.push_back(outcome);
            end
            KIND_RESTART: next_bin = first_bin;
            default: ;
        endcase
    endtask

    task automatic check_result();
        bin_read_t want;
        sum_t      got_re;
        sum_t      got_im;
        got_re = m_tdata[OUT_BITS-1:0];
        got_im = m_tdata[2*OUT_BITS-1:OUT_BITS];
        if (read_q.size() == 0) begin
            errs++;
            if (errs <= REPORT_LIMIT)
                $display("Result with no read outstanding: re=%0d im=%0d sat=%0b",
                         got_re, got_im, m_tuser);
        end else begin
            want = read_q.pop_front();
            n_read++;
            if (got_re !== want.re || got_im !== want.im || m_tuser !== want.sat) begin
                errs++;
                if (errs <= REPORT_LIMIT)
                    $display("Read result %0d wrong: expected re=%0d im=%0d sat=%0b, got re=%0d im=%0d sat=%0b",
                             n_read, want.re, want.im, want.sat, got_re, got_im, m_tuser);
            end else if (want.sat) begin
                n_clip++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < NUM_BINS; b++) begin
                bin_sum_re[b] = '0;
                bin_sum_im[b] = '0;
                bin_sat[b]    = 1'b0;
            end
            fold_len  = RESET_FOLD_LEN;
            first_bin = 0;
            next_bin  = 0;
            read_q.delete();
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (cfg_we) apply_reg_write(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready) begin
                n_req++;
                take_request(s_tuser, s_tdata);
            end
        end
        mismatches    <= errs;
        pending       <= read_q.size();
        requests_seen <= n_req;
        reads_checked <= n_read;
        clipped_reads <= n_clip;
    end

endmodule

// File: sim/testbench.sv
// Top of the periodic fold accumulator test: clock, reset, request and register-write
// stimulus, result back-pressure, watchdog and verdict. Depends on pfa_pkg, pfa_checker
// and periodic_fold_accumulator_unit.
module testbench;
    import pfa_pkg::*;

    localparam int S_TDATA_W     = ((2 * DEF_SAMPLE_BITS + INDEX_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int QUIET_FROM    = 1050;
    localparam int HOLD_AT       = 400;
    localparam int PAUSE_AT      = 700;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int STALL_LIMIT   = 4000;
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [S_TDATA_W-1:0]      s_tdata;
    logic [KIND_BITS-1:0]      s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [2*OUT_BITS-1:0]     m_tdata;
    logic                      m_tuser;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [LEN_BITS-1:0]       cfg_wdata;

    int          mismatches;
    int          pending;
    int          requests_seen;
    int          reads_checked;
    int          clipped_reads;
    int          sent         = 0;
    int          reg_writes   = 0;
    int          stall_cycles = 0;
    int unsigned cur_len      = DEF_MAX_BINS;
    bit          quiet        = 1'b0;
    bit          hold_req     = 1'b0;
    bit          finishing    = 1'b0;

    periodic_fold_accumulator_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pfa_checker #(
        .NUM_BINS  (DEF_MAX_BINS),
        .S_TDATA_W (S_TDATA_W)
    ) result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .requests_seen (requests_seen),
        .reads_checked (reads_checked),
        .clipped_reads (clipped_reads)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Result side: short random stalls, plus one long hold-off on request.
    initial begin
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (!finishing && stall_cycles >= STALL_LIMIT) begin
            $display("No request or result moved for %0d cycles.", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [DEF_SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1: return 16'($urandom_range(0, 200) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    // Valid stays high from one request to the next unless a gap is inserted.
    task automatic send_req(input logic [KIND_BITS-1:0] kind,
                            input logic [DEF_SAMPLE_BITS-1:0] re,
                            input logic [DEF_SAMPLE_BITS-1:0] im,
                            input logic [INDEX_BITS-1:0] idx);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({idx, im, re});
        do @(posedge aclk); while (!s_tready);
        if (kind != KIND_UNUSED) sent++;
    endtask

    task automatic accum(input logic [DEF_SAMPLE_BITS-1:0] re,
                         input logic [DEF_SAMPLE_BITS-1:0] im);
        send_req(KIND_ACCUM, re, im, 10'($urandom));
    endtask

    task automatic read_bin(input logic [INDEX_BITS-1:0] idx);
        send_req(KIND_READ, 16'($urandom), 16'($urandom), idx);
    endtask

    task automatic restart();
        send_req(KIND_RESTART, 16'($urandom), 16'($urandom), 10'($urandom));
    endtask

    // Drops valid and waits until every read has been answered and the block has
    // finished whatever accumulate it was still writing back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [LEN_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        reg_writes++;
        if (idx == REG_FOLD_LENGTH)
            cur_len = (val == 0) ? 1 : ((val > DEF_MAX_BINS) ? DEF_MAX_BINS : val);
    endtask

    task automatic set_fold(input logic [LEN_BITS-1:0] len, input logic [LEN_BITS-1:0] start);
        wait_idle();
        write_reg(REG_FOLD_LENGTH, len);
        write_reg(REG_START_OFFSET, start);
    endtask

    // One frame: usually a restart, a run of samples with some noise mixed in, then
    // reads of bins inside the current period.
    task automatic random_frame();
        int n_samples;
        int n_reads;
        n_samples = $urandom_range(1, (cur_len < 16) ? 3 * cur_len : 48);
        n_reads   = $urandom_range(1, (cur_len < 8) ? cur_len : 8);
        if ($urandom_range(0, 3) != 0) restart();
        repeat (n_samples) begin
            case ($urandom_range(0, 19))
                0: send_req(KIND_UNUSED, 16'($urandom), 16'($urandom), 10'($urandom));
                1: read_bin(10'($urandom));
                2: restart();
                default: accum(rand_sample(), rand_sample());
            endcase
        end
        repeat (n_reads) read_bin(10'($urandom_range(0, cur_len - 1)));
    endtask

    initial begin
        bit hold_done;
        bit pause_done;
        int pick;
        logic [LEN_BITS-1:0] len;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_ACCUM;
        cfg_we     = 1'b0;
        cfg_index  = REG_FOLD_LENGTH;
        cfg_wdata  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: extreme samples, read-and-clear, the top bin, restart and
        // an unused kind.
        accum(16'h7FFF, 16'h8000);
        accum(16'h8000, 16'h7FFF);
        accum(16'h0000, 16'h0000);
        read_bin(0);
        read_bin(0);
        read_bin(10'd1023);
        restart();
        accum(16'h0001, 16'hFFFF);
        send_req(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 10'h3FF);
        read_bin(0);
        read_bin(1);

        // A zero length is taken as one bin; reads past it answer with zeros.
        set_fold(11'd0, 11'h7FF);
        accum(16'h0064, 16'hFF9C);
        accum(16'h7FFF, 16'h7FFF);
        read_bin(0);
        read_bin(1);
        read_bin(10'd1023);

        // An oversized length is clipped to the full store; the walk wraps at the end.
        set_fold(11'h7FF, 11'd1023);
        restart();
        accum(16'h1234, 16'h8765);
        accum(16'h4321, 16'h5678);
        read_bin(10'd1023);
        read_bin(0);

        // A new length folds the position; a new start only counts after a restart.
        wait_idle();
        write_reg(REG_FOLD_LENGTH, 11'd3);
        accum(16'h0010, 16'h0020);
        read_bin(1);
        wait_idle();
        write_reg(REG_START_OFFSET, 11'd2);
        accum(16'h0030, 16'h0040);
        restart();
        accum(16'h0050, 16'h0060);
        read_bin(2);
        read_bin(0);

        while (sent < RANDOM_ITEMS) begin
            if (sent >= QUIET_FROM) quiet <= 1'b1;
            if (!hold_done && sent >= HOLD_AT) begin
                // Reads keep coming while the result side is held off, so the output
                // register fills and the block has to stall its input.
                hold_done = 1'b1;
                hold_req <= 1'b1;
                repeat (12) read_bin(10'($urandom_range(0, cur_len - 1)));
            end
            if (!pause_done && sent >= PAUSE_AT) begin
                pause_done = 1'b1;
                wait_idle();
            end
            if ($urandom_range(0, 5) == 0) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    len = 11'($urandom_range(1, 16));
                else if (pick < 8)
                    len = 11'($urandom_range(17, DEF_MAX_BINS));
                else
                    len = 11'($urandom_range(0, 2047));
                set_fold(len, 11'($urandom_range(0, 2047)));
            end
            random_frame();
        end

        // Two bins: the third sample wraps back onto the first bin.
        set_fold(11'd2, 11'd0);
        restart();
        accum(16'h7FFF, 16'h8000);
        accum(16'h8000, 16'h7FFF);
        accum(16'hFFFF, 16'h0001);
        read_bin(0);
        read_bin(1);
        read_bin(0);

        wait_idle();
        repeat (END_CYCLES) @(posedge aclk);
        finishing = 1'b1;
        $display("Run covered %0d requests and %0d register writes, fold lengths 1 to %0d.",
                 requests_seen, reg_writes, DEF_MAX_BINS);
        $display("%0d read results were compared, %0d of them with the clip flag set.",
                 reads_checked, clipped_reads);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
